>>> rtl/mbs_pkg.sv
// Shared types and constants for the multiset bag store.
package mbs_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int ITEM_WIDTH_DEF = 32;
  localparam int IN_VALUE_W     = 32;
  localparam int FIELD_W        = 7;
  localparam int OUT_DATA_W     = 16;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // Control part of the request token that walks down the cell chain.
  typedef struct packed {
    logic valid;
    req_e op;
    logic found;
  } tok_ctrl_t;

endpackage

>>> rtl/mbs_cell.sv
// One storage cell of the bag chain: holds an entry and forwards the request token.
module mbs_cell import mbs_pkg::*; #(
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CNT_W-1:0]      count_i,
  input  tok_ctrl_t             tok_ctrl_i,
  input  logic [ITEM_WIDTH-1:0] tok_value_i,
  input  logic [CNT_W-1:0]      tok_match_i,
  input  logic [ITEM_WIDTH-1:0] nbr_value_i,
  output tok_ctrl_t             tok_ctrl_o,
  output logic [ITEM_WIDTH-1:0] tok_value_o,
  output logic [CNT_W-1:0]      tok_match_o,
  output logic [ITEM_WIDTH-1:0] value_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic [ITEM_WIDTH-1:0] value_q, value_d;
  tok_ctrl_t             tok_ctrl_q, tok_ctrl_d;
  logic [ITEM_WIDTH-1:0] tok_value_q;
  logic [CNT_W-1:0]      tok_match_q, tok_match_d;
  logic                  hit;

  assign hit = tok_ctrl_i.valid && (Idx < count_i) && (value_q == tok_value_i);

  always_comb begin
    value_d = value_q;
    if (tok_ctrl_i.valid && tok_ctrl_i.op == REQ_ADD && Idx == count_i) begin
      value_d = tok_value_i;
    end else if (tok_ctrl_i.valid && tok_ctrl_i.op == REQ_REMOVE &&
                 (tok_ctrl_i.found || hit)) begin
      // close the gap: take the upper neighbor's entry
      value_d = nbr_value_i;
    end
  end

  always_comb begin
    tok_ctrl_d       = tok_ctrl_i;
    tok_ctrl_d.found = tok_ctrl_i.found | hit;
    tok_match_d      = tok_match_i + CNT_W'(hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_ctrl_q <= '0;
    end else begin
      tok_ctrl_q <= tok_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    tok_value_q <= tok_value_i;
    tok_match_q <= tok_match_d;
  end

  assign tok_ctrl_o  = tok_ctrl_q;
  assign tok_value_o = tok_value_q;
  assign tok_match_o = tok_match_q;
  assign value_o     = value_q;

endmodule

>>> rtl/multiset_bag_store.sv
// Multiset bag store: bounded bag of values kept in a chain of storage cells.
// A result word is registered once the request token has left the last cell.
// A new request is taken only after the last token has left; the token visits one
//   cell per cycle, so the chain length sets the time between requests.
// A finished result waits in the output register while the next request runs; one parked
//   in the holding slot blocks new requests. Reset empties the bag; cells keep contents.
module multiset_bag_store import mbs_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request side
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_VALUE_W-1:0] s_axis_tdata_i,   // [31:0] item_value
  input  logic [1:0]            s_axis_tuser_i,   // [1:0] req_type
  // result side
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [0] success, [7:1] match_count, [14:8] bag_size, [15] bag_empty
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  // Token links between cells; link 0 feeds the first cell.
  tok_ctrl_t             tok_ctrl [CAPACITY+1];
  logic [ITEM_WIDTH-1:0] tok_value[CAPACITY+1];
  logic [CNT_W-1:0]      tok_match[CAPACITY+1];
  logic [ITEM_WIDTH-1:0] cell_value[CAPACITY];

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  busy_q, busy_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [OUT_DATA_W-1:0] pend_data_q, pend_data_d;

  logic                  in_fire;
  logic                  tok_exit;
  logic                  out_free;
  logic [ITEM_WIDTH+IN_VALUE_W-1:0] in_ext;
  logic                  res_success;
  logic [CNT_W-1:0]      res_match;
  logic [CNT_W+FIELD_W-1:0] match_ext;
  logic [CNT_W+FIELD_W-1:0] size_ext;
  logic [OUT_DATA_W-1:0] res_data;

  // Accept a new request only when no other is in the chain and the holding slot is free.
  assign s_axis_tready_o = !busy_q && !pend_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Drop value bits above ITEM_WIDTH, zero-extend when ITEM_WIDTH is wider.
  assign in_ext = {{ITEM_WIDTH{1'b0}}, s_axis_tdata_i};

  always_comb begin
    tok_ctrl[0].valid = in_fire;
    tok_ctrl[0].op    = req_e'(s_axis_tuser_i);
    tok_ctrl[0].found = 1'b0;
    tok_value[0]      = in_ext[ITEM_WIDTH-1:0];
    tok_match[0]      = '0;
  end

  // Cell chain: cell 0 sees the token on acceptance; each cell registers it for the next.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] nbr_value;
    if (i == CAPACITY - 1) begin : g_top
      assign nbr_value = cell_value[i];
    end else begin : g_mid
      assign nbr_value = cell_value[i+1];
    end

    mbs_cell #(
      .ITEM_WIDTH (ITEM_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .count_i     (count_q),
      .tok_ctrl_i  (tok_ctrl[i]),
      .tok_value_i (tok_value[i]),
      .tok_match_i (tok_match[i]),
      .nbr_value_i (nbr_value),
      .tok_ctrl_o  (tok_ctrl[i+1]),
      .tok_value_o (tok_value[i+1]),
      .tok_match_o (tok_match[i+1]),
      .value_o     (cell_value[i])
    );
  end

  assign tok_exit = tok_ctrl[CAPACITY].valid;

  // Finish the request once the token leaves the last cell.
  always_comb begin
    count_d     = count_q;
    res_success = 1'b0;
    res_match   = tok_match[CAPACITY];
    unique case (tok_ctrl[CAPACITY].op)
      REQ_ADD: begin
        if (count_q != CapCnt) begin
          count_d     = count_q + CNT_W'(1);
          res_success = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (tok_ctrl[CAPACITY].found) begin
          count_d     = count_q - CNT_W'(1);
          res_success = 1'b1;
        end
      end
      REQ_QUERY: begin
        res_success = tok_ctrl[CAPACITY].found;
      end
      REQ_CLEAR: begin
        count_d     = '0;
        res_success = 1'b1;
        res_match   = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (!tok_exit) begin
      count_d = count_q;
    end
  end

  // Fit counts into the 7-bit result fields.
  assign match_ext = {{FIELD_W{1'b0}}, res_match};
  assign size_ext  = {{FIELD_W{1'b0}}, count_d};
  assign res_data  = {(count_d == '0), size_ext[FIELD_W-1:0], match_ext[FIELD_W-1:0],
                      res_success};

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    pend_valid_d = pend_valid_q;
    pend_data_d  = pend_data_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end
    if (tok_exit) begin
      busy_d = 1'b0;
    end
    if (out_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = pend_data_q;
        pend_valid_d = 1'b0;
      end else if (tok_exit) begin
        out_valid_d = 1'b1;
        out_data_d  = res_data;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (tok_exit) begin
      // output still held: park the result
      pend_valid_d = 1'b1;
      pend_data_d  = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    pend_data_q <= pend_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("bag count above capacity");

  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_exit |-> busy_q)
    else $error("token left the chain with no request in flight");

  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q)
    else $error("request accepted but chain not marked busy");

  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("parked result with empty output register");

  a_busy_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pend_valid_q)
    else $error("request in flight while a result is parked");
`endif

endmodule

>>> dv/multiset_bag_store_tb.sv
// Self-checking stream testbench for the multiset bag store.
`timescale 1ns / 1ps

module multiset_bag_store_tb;
  import mbs_pkg::*;

  localparam int CAP      = CAPACITY_DEF;
  localparam int ITEM_W   = ITEM_WIDTH_DEF;
  localparam int LATENCY  = CAP + 1;
  localparam int IDLE_MAX = 3000;
  localparam int N_ITEMS  = 450;
  localparam logic [IN_VALUE_W-1:0] VAL_MASK = {IN_VALUE_W{1'b1}} >> (IN_VALUE_W - ITEM_W);

  // Receiver stall patterns.
  localparam logic [1:0] RX_STEADY   = 2'd0;
  localparam logic [1:0] RX_JITTER   = 2'd1;
  localparam logic [1:0] RX_BLOCKING = 2'd2;

  // Random episode flavors: which way the bag is pushed.
  localparam int EP_GROW   = 0;
  localparam int EP_MIXED  = 1;
  localparam int EP_SHRINK = 2;

  // Result word, laid out exactly as m_axis_tdata_o (bag_empty in the top bit).
  typedef struct packed {
    logic                bag_empty;
    logic [FIELD_W-1:0]  bag_size;
    logic [FIELD_W-1:0]  match_count;
    logic                success;
  } bag_result_t;

  // One row of the directed table; typed rows carry their result written out.
  typedef struct {
    req_e                  op;
    logic [IN_VALUE_W-1:0] value;
    bit                    typed;
    bag_result_t           want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_VALUE_W-1:0] s_axis_tdata_i = '0;
  logic [1:0]            s_axis_tuser_i = REQ_QUERY;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  multiset_bag_store #(
    .CAPACITY   (CAP),
    .ITEM_WIDTH (ITEM_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow bag: the stack as the block should hold it.
  logic [IN_VALUE_W-1:0] bag_mem [CAP];
  int                    bag_fill = 0;

  // Results owed by the block, oldest first.
  bag_result_t owed_results [$];
  dir_row_t    dir_rows [$];

  int err_count    = 0;
  int words_seen   = 0;
  int words_sent   = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int op_seen [4]  = '{0, 0, 0, 0};
  int full_refused = 0;
  int peak_match   = 0;
  int peak_size    = 0;

  // Apply one request to the shadow bag and return the word it must produce.
  function automatic bag_result_t apply_request(req_e op, logic [IN_VALUE_W-1:0] raw);
    logic [IN_VALUE_W-1:0] key;
    int                    hits;
    int                    newest;
    bag_result_t           res;
    key    = raw & VAL_MASK;
    hits   = 0;
    newest = -1;
    for (int i = 0; i < bag_fill; i++) begin
      if (bag_mem[i] == key) begin
        hits++;
        newest = i;
      end
    end
    res.success = 1'b0;
    case (op)
      REQ_ADD: begin
        if (bag_fill < CAP) begin
          bag_mem[bag_fill] = key;
          bag_fill++;
          res.success = 1'b1;
        end
      end
      REQ_REMOVE: begin
        // Newest match takes the head value, then the head is dropped.
        if (newest >= 0) begin
          bag_mem[newest] = bag_mem[bag_fill-1];
          bag_fill--;
          res.success = 1'b1;
        end
      end
      REQ_QUERY: res.success = (hits > 0);
      default: begin
        bag_fill    = 0;
        hits        = 0;
        res.success = 1'b1;
      end
    endcase
    res.match_count = FIELD_W'(hits);
    res.bag_size    = FIELD_W'(bag_fill);
    res.bag_empty   = (bag_fill == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
             words_seen, what, got, want);
    err_count++;
  endtask

  // Table entry; typed rows are checked against the written-out word.
  task automatic add_row(req_e op, logic [IN_VALUE_W-1:0] value, bit typed = 1'b0,
                         logic ok = 1'b0, int hits = 0, int fill = 0, logic empty = 1'b0);
    dir_row_t row;
    row.op        = op;
    row.value     = value;
    row.typed     = typed;
    row.want      = '{empty, FIELD_W'(fill), FIELD_W'(hits), ok};
    dir_rows      = {dir_rows, row};
  endtask

  // Drive one request word; return at the edge where it is taken.
  // Bursts of back-to-back words are broken by random gaps on the valid line.
  task automatic send_word(req_e op, logic [IN_VALUE_W-1:0] value,
                           bit typed = 1'b0, bag_result_t want = '0);
    int          gap;
    bag_result_t pred;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 140);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    // Accepted at this edge: run the shadow bag regardless of how it is checked.
    pred = apply_request(op, value);
    owed_results = {owed_results, (typed ? want : pred)};
    burst_left--;
    words_sent++;
    op_seen[op]++;
    if (op == REQ_ADD && !pred.success) full_refused++;
    if (int'(pred.match_count) > peak_match) peak_match = int'(pred.match_count);
    if (int'(pred.bag_size) > peak_size) peak_size = int'(pred.bag_size);
  endtask

  // Hold the request side until every owed result has been taken.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left      = 0;
    do @(posedge clk_i); while (owed_results.size() != 0);
  endtask

  // Result receiver: steady, jittery or long blocking stalls, in a pattern redrawn at random.
  logic [1:0] rx_mode  = RX_STEADY;
  int         rx_hold  = 0;
  int         rx_cycle = 0;

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 1024 == 0) rx_mode <= 2'($urandom_range(0, 2));
    if (rx_hold != 0) begin
      rx_hold         <= rx_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      case (rx_mode)
        RX_JITTER: begin
          if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 4);
        end
        RX_BLOCKING: begin
          if ($urandom_range(0, 40) == 0) rx_hold <= $urandom_range(20, 150);
        end
        default: ;
      endcase
    end
  end

  // Result checker and watchdog. Signals are read at the edge, before any update lands.
  always @(posedge clk_i) begin
    bag_result_t got;
    bag_result_t want;
    if (rst_ni) begin
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = bag_result_t'(m_axis_tdata_o);
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected word", int'(m_axis_tdata_o), 0);
        end else begin
          want = owed_results.pop_front();
          if (got.success !== want.success)
            report_mismatch("success", int'(got.success), int'(want.success));
          if (got.match_count !== want.match_count)
            report_mismatch("match_count", int'(got.match_count), int'(want.match_count));
          if (got.bag_size !== want.bag_size)
            report_mismatch("bag_size", int'(got.bag_size), int'(want.bag_size));
          if (got.bag_empty !== want.bag_empty)
            report_mismatch("bag_empty", int'(got.bag_empty), int'(want.bag_empty));
        end
        words_seen <= words_seen + 1;
      end
      if (idle_cycles >= IDLE_MAX) begin
        $display("Timeout: no word moved for %0d cycles, %0d results still owed",
                 IDLE_MAX, owed_results.size());
        $display("multiset_bag_store test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [IN_VALUE_W-1:0] pool [16];
    int                    pool_n;
    int                    kind;
    int                    ep_len;
    int                    episode;
    int                    roll;
    int                    add_pct;
    int                    rem_pct;
    int                    qry_pct;
    req_e                  op;
    logic [IN_VALUE_W-1:0] value;

    // Directed table: empty-bag corner cases first, then value extremes and
    // remove order (newest match is overwritten by the head).
    add_row(REQ_QUERY,  32'h0000_0000, 1'b1, 1'b0, 0, 0, 1'b1);
    add_row(REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0, 1'b1);
    add_row(REQ_CLEAR,  32'h0000_0000, 1'b1, 1'b1, 0, 0, 1'b1);
    add_row(REQ_ADD,    32'h0000_0000, 1'b1, 1'b1, 0, 1, 1'b0);
    add_row(REQ_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1, 0, 2, 1'b0);
    add_row(REQ_ADD,    32'h0000_0000, 1'b1, 1'b1, 1, 3, 1'b0);
    add_row(REQ_ADD,    32'h8000_0001);
    add_row(REQ_QUERY,  32'h0000_0000);
    add_row(REQ_QUERY,  32'hFFFF_FFFF);
    add_row(REQ_QUERY,  32'h0000_0001);
    add_row(REQ_REMOVE, 32'h0000_0000);
    add_row(REQ_QUERY,  32'h8000_0001);
    add_row(REQ_REMOVE, 32'h1234_5678);
    add_row(REQ_REMOVE, 32'hFFFF_FFFF);
    add_row(REQ_REMOVE, 32'h0000_0000);
    add_row(REQ_REMOVE, 32'h8000_0001);
    add_row(REQ_QUERY,  32'h8000_0001);
    add_row(REQ_ADD,    32'h5A5A_5A5A);
    add_row(REQ_ADD,    32'hA5A5_A5A5);
    // Clear ignores its value field.
    add_row(REQ_CLEAR,  32'hDEAD_BEEF, 1'b1, 1'b1, 0, 0, 1'b1);
    add_row(REQ_QUERY,  32'h5A5A_5A5A, 1'b1, 1'b0, 0, 0, 1'b1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
    end
    // Pause the sender until every directed result is back.
    drain_results();

    // Random episodes: grow, mix or shrink the bag over a small value pool so
    // that matches, duplicate removal and the full bag all come up. The first
    // episode fills the bag with one value to reach the top match count.
    episode = 0;
    while (words_sent < N_ITEMS) begin
      kind   = (episode == 0) ? EP_GROW : $urandom_range(EP_GROW, EP_SHRINK);
      pool_n = (episode == 0) ? 1 : (1 << $urandom_range(0, 4));
      if (pool_n > 16) pool_n = 16;
      ep_len = (episode == 0) ? 100 : $urandom_range(40, 110);
      foreach (pool[i]) pool[i] = $urandom;
      case (kind)
        EP_GROW:  begin add_pct = 85; rem_pct = 5;  qry_pct = 9;  end
        EP_MIXED: begin add_pct = 40; rem_pct = 30; qry_pct = 28; end
        default:  begin add_pct = 10; rem_pct = 70; qry_pct = 18; end
      endcase
      repeat (ep_len) begin
        if (words_sent >= N_ITEMS) break;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)                          op = REQ_ADD;
        else if (roll < add_pct + rem_pct)           op = REQ_REMOVE;
        else if (roll < add_pct + rem_pct + qry_pct) op = REQ_QUERY;
        else                                         op = REQ_CLEAR;
        // Mostly pool values; now and then a fully random word as noise.
        value = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
        send_word(op, value);
      end
      // Hold off now and then until the block has caught up.
      if ($urandom_range(0, 2) == 0) drain_results();
      episode++;
    end

    drain_results();
    // Let any stray word surface before judging.
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Covered %0d add, %0d remove, %0d query and %0d clear requests in %0d episodes",
             op_seen[REQ_ADD], op_seen[REQ_REMOVE], op_seen[REQ_QUERY], op_seen[REQ_CLEAR],
             episode);
    $display("Peak bag size %0d, peak match count %0d, %0d adds refused on a full bag",
             peak_size, peak_match, full_refused);
    if (err_count == 0) begin
      $display("multiset_bag_store test passed");
    end else begin
      $display("multiset_bag_store test failed");
    end
    $finish;
  end

endmodule
